// ===== hdl/kstm_pkg.sv =====
package kstm_pkg;

    localparam int NUM_KEYS  = 17;
    localparam int KEY_IDX_W = $clog2(NUM_KEYS);

    // configuration register indexes
    localparam logic [1:0] CFG_VELOCITY_STEP = 2'd0;
    localparam logic [1:0] CFG_MOD_STEP_HALF = 2'd1;
    localparam logic [1:0] CFG_OCTAVE_MAX    = 2'd2;

    // event kinds
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_NOTE_ON  = 3'd1;
    localparam logic [2:0] EV_NOTE_OFF = 3'd2;
    localparam logic [2:0] EV_BEND     = 3'd3;
    localparam logic [2:0] EV_CTRL     = 3'd4;

    localparam logic [13:0] BEND_CENTER  = 14'd8192;
    localparam logic [13:0] BEND_MAX     = 14'd16383;
    localparam logic [6:0]  NOTE_MAX     = 7'd127;
    localparam logic [7:0]  MOD_HALF_MAX = 8'd254;
    localparam logic [6:0]  CC_MODULATION = 7'd1;

    localparam logic [6:0] VELOCITY_STEP_RST = 7'd20;
    localparam logic [7:0] MOD_STEP_RST      = 8'd5;
    localparam logic [3:0] OCTAVE_MAX_RST    = 4'd8;
    localparam logic [3:0] OCTAVE_RST        = 4'd3;
    localparam logic [6:0] VELOCITY_RST      = 7'd100;

    localparam int JOB_FIFO_DEPTH = 2;
    localparam int JOB_PTR_W      = $clog2(JOB_FIFO_DEPTH);

    // one classified request, handed from front to back
    typedef struct packed {
        logic                notes_en;
        logic                is_scan;
        logic                handled_base;
        logic [NUM_KEYS-1:0] keys;
        logic [3:0]          octave;
        logic [6:0]          velocity;
        logic                bend_en;
        logic [13:0]         bend_val;
        logic                cc_en;
        logic [6:0]          cc_val;
    } job_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    // semitone offset of each note key above the octave base
    function automatic logic [4:0] key_offset(input logic [KEY_IDX_W-1:0] idx);
        logic [4:0] off;
        off = 5'd0;
        case (idx)
            5'd0:    off = 5'd0;
            5'd1:    off = 5'd1;
            5'd2:    off = 5'd2;
            5'd3:    off = 5'd3;
            5'd4:    off = 5'd4;
            5'd5:    off = 5'd5;
            5'd6:    off = 5'd6;
            5'd7:    off = 5'd7;
            5'd8:    off = 5'd8;
            5'd9:    off = 5'd9;
            5'd10:   off = 5'd10;
            5'd11:   off = 5'd11;
            5'd12:   off = 5'd12;
            5'd13:   off = 5'd14;
            5'd14:   off = 5'd15;
            5'd15:   off = 5'd16;
            5'd16:   off = 5'd17;
            default: off = 5'd0;
        endcase
        return off;
    endfunction

endpackage

// ===== hdl/kstm_ifs.sv =====
interface key_scan_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic                          enable_value;
    logic                          from_text_field;
    logic [kstm_pkg::NUM_KEYS-1:0] note_keys;
    logic                          octave_down_key;
    logic                          octave_up_key;
    logic                          velocity_down_key;
    logic                          velocity_up_key;
    logic                          bend_up_key;
    logic                          bend_down_key;
    logic                          mod_down_key;
    logic                          mod_up_key;

    modport source (
        output valid, req_type, enable_value, from_text_field, note_keys,
               octave_down_key, octave_up_key, velocity_down_key, velocity_up_key,
               bend_up_key, bend_down_key, mod_down_key, mod_up_key,
        input  ready
    );
    modport sink (
        input  valid, req_type, enable_value, from_text_field, note_keys,
               octave_down_key, octave_up_key, velocity_down_key, velocity_up_key,
               bend_up_key, bend_down_key, mod_down_key, mod_up_key,
        output ready
    );
endinterface

interface midi_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [6:0]  data_first;
    logic [13:0] data_value;
    logic        handled;
    logic        last_result;

    modport source (
        output valid, event_kind, data_first, data_value, handled, last_result,
        input  ready
    );
    modport sink (
        input  valid, event_kind, data_first, data_value, handled, last_result,
        output ready
    );
endinterface

interface cfg_write_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/kstm_front.sv =====
module kstm_front (
    input  logic           clk,
    input  logic           rst_n,
    key_scan_if.sink       scan_in,
    cfg_write_if.sink      cfg,
    output logic           job_push,
    output kstm_pkg::job_t job_data,
    input  logic           job_full
);
    import kstm_pkg::*;

    logic [6:0] velocity_step_reg;
    logic [7:0] mod_step_reg;
    logic [3:0] octave_max_reg;

    logic       enabled_reg, enabled_next;
    logic [3:0] octave_reg, octave_next;
    logic [6:0] velocity_reg, velocity_next;
    logic [3:0] ctl_prev_reg, ctl_prev_next;
    logic [1:0] arrows_prev_reg, arrows_prev_next;
    logic [7:0] mod_half_reg, mod_half_next;

    logic       accept;
    logic [3:0] ctl;
    logic [3:0] rise;
    logic [1:0] arrows;
    logic [3:0] oct_dn;
    logic [6:0] vel_dn;
    logic [8:0] mod_sum;
    logic [6:0] mod_whole;
    job_t       job;

    assign scan_in.ready = !job_full;
    assign cfg.ready     = 1'b1;
    assign accept        = scan_in.valid && !job_full;

    assign ctl    = {scan_in.velocity_up_key, scan_in.velocity_down_key,
                     scan_in.octave_up_key, scan_in.octave_down_key};
    assign rise   = ctl & ~ctl_prev_reg;
    assign arrows = {scan_in.bend_down_key, scan_in.bend_up_key};

    // saturating counters, down step first then up step
    assign oct_dn = !rise[0] ? octave_reg :
                    (octave_reg != 4'd0 ? octave_reg - 4'd1 : 4'd0);
    assign vel_dn = !rise[2] ? velocity_reg :
                    (({1'b0, velocity_reg} > ({1'b0, velocity_step_reg} + 8'd1))
                        ? velocity_reg - velocity_step_reg : 7'd1);
    assign mod_sum = {1'b0, mod_half_reg} + {1'b0, mod_step_reg};

    always_comb
    begin
        enabled_next     = enabled_reg;
        octave_next      = octave_reg;
        velocity_next    = velocity_reg;
        ctl_prev_next    = ctl_prev_reg;
        arrows_prev_next = arrows_prev_reg;
        mod_half_next    = mod_half_reg;
        job              = '0;
        mod_whole        = 7'd0;

        if (accept)
        begin
            if (scan_in.req_type)
            begin
                enabled_next = scan_in.enable_value;
                if (!scan_in.enable_value)
                begin
                    // release all sounding keys and center the bend
                    job.notes_en     = 1'b1;
                    job.bend_en      = 1'b1;
                    job.bend_val     = BEND_CENTER;
                    arrows_prev_next = 2'b00;
                end
            end
            else if (enabled_reg && !scan_in.from_text_field)
            begin
                octave_next = oct_dn;
                if (rise[1])
                begin
                    octave_next = (({1'b0, oct_dn} + 5'd1) < {1'b0, octave_max_reg})
                                  ? oct_dn + 4'd1 : octave_max_reg;
                end
                velocity_next = vel_dn;
                if (rise[3])
                begin
                    velocity_next = (({1'b0, vel_dn} + {1'b0, velocity_step_reg})
                                     < {1'b0, NOTE_MAX})
                                    ? vel_dn + velocity_step_reg : NOTE_MAX;
                end
                ctl_prev_next = ctl;

                job.notes_en     = 1'b1;
                job.is_scan      = 1'b1;
                job.keys         = scan_in.note_keys;
                job.octave       = octave_next;
                job.velocity     = velocity_next;
                job.handled_base = (ctl != 4'd0) || (arrows != 2'b00);

                if (arrows != arrows_prev_reg)
                begin
                    arrows_prev_next = arrows;
                    job.bend_en      = 1'b1;
                    job.handled_base = 1'b1;
                    if (arrows == 2'b01)
                        job.bend_val = BEND_MAX;
                    else if (arrows == 2'b10)
                        job.bend_val = 14'd0;
                    else
                        job.bend_val = BEND_CENTER;
                end

                if (scan_in.mod_up_key || scan_in.mod_down_key)
                begin
                    if (scan_in.mod_up_key)
                        mod_half_next = (mod_sum > {1'b0, MOD_HALF_MAX})
                                        ? MOD_HALF_MAX : mod_sum[7:0];
                    else
                        mod_half_next = (mod_half_reg > mod_step_reg)
                                        ? mod_half_reg - mod_step_reg : 8'd0;
                    // half units to whole, round half to even
                    mod_whole        = mod_half_next[7:1];
                    job.cc_en        = 1'b1;
                    job.cc_val       = mod_whole + {6'd0, mod_half_next[0] & mod_whole[0]};
                    job.handled_base = 1'b1;
                end
            end
        end
    end

    assign job_push = accept;
    assign job_data = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            velocity_step_reg <= VELOCITY_STEP_RST;
            mod_step_reg      <= MOD_STEP_RST;
            octave_max_reg    <= OCTAVE_MAX_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_VELOCITY_STEP: velocity_step_reg <= cfg.data[6:0];
                CFG_MOD_STEP_HALF: mod_step_reg      <= cfg.data;
                CFG_OCTAVE_MAX:    octave_max_reg    <= cfg.data[3:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b1;
            octave_reg      <= OCTAVE_RST;
            velocity_reg    <= VELOCITY_RST;
            ctl_prev_reg    <= 4'd0;
            arrows_prev_reg <= 2'b00;
            mod_half_reg    <= 8'd0;
        end
        else
        begin
            enabled_reg     <= enabled_next;
            octave_reg      <= octave_next;
            velocity_reg    <= velocity_next;
            ctl_prev_reg    <= ctl_prev_next;
            arrows_prev_reg <= arrows_prev_next;
            mod_half_reg    <= mod_half_next;
        end
    end

endmodule

// ===== hdl/kstm_job_fifo.sv =====
module kstm_job_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  kstm_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output kstm_pkg::job_t pop_data,
    output logic           empty
);
    import kstm_pkg::*;

    localparam int CNT_W = $clog2(JOB_FIFO_DEPTH + 1);

    job_t                 slot_reg [JOB_FIFO_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOB_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign full     = (count_reg == CNT_W'(JOB_FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == JOB_PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0
                          : wr_ptr_reg + JOB_PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == JOB_PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0
                          : rd_ptr_reg + JOB_PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/kstm_back.sv =====
module kstm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  kstm_pkg::job_t job,
    output logic           job_pop,
    midi_event_if.source   event_out
);
    import kstm_pkg::*;

    back_state_t         state_reg, state_next;
    job_t                job_reg, job_next;
    logic [NUM_KEYS-1:0] mask_reg, mask_next;
    logic [NUM_KEYS-1:0] active_reg, active_next;
    logic                handled_reg, handled_next;
    logic                bend_pend_reg, bend_pend_next;
    logic                cc_pend_reg, cc_pend_next;
    logic [6:0]          key_note_reg [NUM_KEYS];

    logic                out_valid_reg, out_valid_next;
    logic [2:0]          out_kind_reg, out_kind_next;
    logic [6:0]          out_first_reg, out_first_next;
    logic [13:0]         out_value_reg, out_value_next;
    logic                out_handled_reg, out_handled_next;
    logic                out_last_reg, out_last_next;

    logic                 emit_ok;
    logic                 last;
    logic                 note_wr;
    logic [KEY_IDX_W-1:0] idx;
    logic [NUM_KEYS-1:0]  rest;
    logic [NUM_KEYS-1:0]  released;
    logic [8:0]           note_sum;
    logic [6:0]           note;

    // lowest pending key
    function automatic logic [KEY_IDX_W-1:0] first_set(input logic [NUM_KEYS-1:0] m);
        logic [KEY_IDX_W-1:0] r;
        r = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (m[i])
                r = KEY_IDX_W'(i);
        end
        return r;
    endfunction

    assign idx      = first_set(mask_reg);
    assign rest     = mask_reg & (mask_reg - NUM_KEYS'(1));
    assign released = active_reg & ~job.keys;
    assign note_sum = ({5'd0, job_reg.octave} << 3) + ({5'd0, job_reg.octave} << 2)
                      + {4'd0, key_offset(idx)};
    assign note     = (note_sum > {2'b00, NOTE_MAX}) ? NOTE_MAX : note_sum[6:0];
    assign emit_ok  = !out_valid_reg || event_out.ready;

    always_comb
    begin
        state_next       = state_reg;
        job_next         = job_reg;
        mask_next        = mask_reg;
        active_next      = active_reg;
        handled_next     = handled_reg;
        bend_pend_next   = bend_pend_reg;
        cc_pend_next     = cc_pend_reg;
        out_valid_next   = out_valid_reg && !event_out.ready;
        out_kind_next    = out_kind_reg;
        out_first_next   = out_first_reg;
        out_value_next   = out_value_reg;
        out_handled_next = out_handled_reg;
        out_last_next    = out_last_reg;
        job_pop          = 1'b0;
        note_wr          = 1'b0;
        last             = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop        = 1'b1;
                    job_next       = job;
                    mask_next      = job.notes_en ? (job.keys ^ active_reg) : '0;
                    handled_next   = job.handled_base ||
                                     (job.is_scan && ((job.keys != '0) || (released != '0)));
                    bend_pend_next = job.bend_en;
                    cc_pend_next   = job.cc_en;
                    state_next     = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    if (mask_reg != '0)
                    begin
                        mask_next = rest;
                        last      = (rest == '0) && !bend_pend_reg && !cc_pend_reg;
                        if (job_reg.keys[idx])
                        begin
                            out_kind_next    = EV_NOTE_ON;
                            out_first_next   = note;
                            out_value_next   = {7'd0, job_reg.velocity};
                            active_next[idx] = 1'b1;
                            note_wr          = 1'b1;
                        end
                        else
                        begin
                            out_kind_next    = EV_NOTE_OFF;
                            out_first_next   = key_note_reg[idx];
                            out_value_next   = 14'd0;
                            active_next[idx] = 1'b0;
                        end
                    end
                    else if (bend_pend_reg)
                    begin
                        bend_pend_next = 1'b0;
                        last           = !cc_pend_reg;
                        out_kind_next  = EV_BEND;
                        out_first_next = 7'd0;
                        out_value_next = job_reg.bend_val;
                    end
                    else if (cc_pend_reg)
                    begin
                        cc_pend_next   = 1'b0;
                        last           = 1'b1;
                        out_kind_next  = EV_CTRL;
                        out_first_next = CC_MODULATION;
                        out_value_next = {7'd0, job_reg.cc_val};
                    end
                    else
                    begin
                        last           = 1'b1;
                        out_kind_next  = EV_NONE;
                        out_first_next = 7'd0;
                        out_value_next = 14'd0;
                    end
                    out_last_next    = last;
                    out_handled_next = last && handled_reg;
                    if (last)
                        state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (note_wr)
            key_note_reg[idx] <= note;
    end

    always_ff @(posedge clk)
    begin
        job_reg         <= job_next;
        mask_reg        <= mask_next;
        handled_reg     <= handled_next;
        out_kind_reg    <= out_kind_next;
        out_first_reg   <= out_first_next;
        out_value_reg   <= out_value_next;
        out_handled_reg <= out_handled_next;
        out_last_reg    <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            active_reg    <= '0;
            bend_pend_reg <= 1'b0;
            cc_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            bend_pend_reg <= bend_pend_next;
            cc_pend_reg   <= cc_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign event_out.valid       = out_valid_reg;
    assign event_out.event_kind  = out_kind_reg;
    assign event_out.data_first  = out_first_reg;
    assign event_out.data_value  = out_value_reg;
    assign event_out.handled     = out_handled_reg;
    assign event_out.last_result = out_last_reg;

endmodule

// ===== hdl/key_scan_to_midi_events_unit.sv =====
// key scan to midi event converter
// scan_in takes one request per handshake: a key-state scan or a set-enable
// request. event_out delivers the midi events that request causes, one per
// handshake, note events by rising key index, then pitch bend, then
// controller 1; the last one carries last_result and the handled flag. a
// request with no event still yields one result of kind none.
// cfg writes velocity step (index 0), modulation step (1) and octave limit (2);
// write it only while no request is in flight.
// the front classifies a request in the cycle it is accepted and updates the
// octave, velocity, bend and modulation state, then queues a job (two deep).
// the back loads a job and then emits one event per cycle while event_out is
// ready, taking no new job until the last result of the current one; the
// back's one-event-per-cycle walk over changed keys sets the throughput. a
// result passes the job queue, the back's job register and the output register.
// a stalled event_out holds its output register and the back; the front keeps
// accepting until the job queue is full, then drops scan_in.ready.
// reset clears the queue and the set of sounding keys; enable is on, octave 3,
// velocity 100, modulation 0, registers at their defaults.
module key_scan_to_midi_events_unit (
    input  logic         clk,
    input  logic         rst_n,
    key_scan_if.sink     scan_in,
    midi_event_if.source event_out,
    cfg_write_if.sink    cfg
);
    import kstm_pkg::*;

    // job handoff between front and back
    logic job_push;
    logic job_full;
    logic job_pop;
    logic job_empty;
    job_t job_in;
    job_t job_out;

    // front: config registers, counters, request classification
    kstm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .scan_in  (scan_in),
        .cfg      (cfg),
        .job_push (job_push),
        .job_data (job_in),
        .job_full (job_full)
    );

    // short decoupling queue
    kstm_job_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .empty     (job_empty)
    );

    // back: key memory and event sequencing
    kstm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .event_out (event_out)
    );

endmodule
